@@ design/lpr_pkg.sv @@
// Package for the longest-prefix route lookup block.
// Holds the table size, the action codes, the route entry record and the
// control/result structs shared by the lookup datapath and its sequencer.
package lpr_pkg;

  localparam int ROUTES = 16;
  localparam int PORTS  = 4;
  localparam int IDX_W  = (ROUTES > 1) ? $clog2(ROUTES) : 1;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // One stored route, as kept in the route RAM
  typedef struct packed {
    logic [31:0] gateway;
    logic [31:0] mask;
    logic [31:0] prefix;
    logic [1:0]  port;
  } entry_t;

  // Sequencer to compare unit
  typedef struct packed {
    logic             clear;
    logic             step;
    logic             in_use;
    logic [IDX_W-1:0] idx;
  } cmp_ctrl_t;

  // Best match held by the compare unit
  typedef struct packed {
    logic             found;
    logic [31:0]      gateway;
    logic [1:0]       port;
    logic [IDX_W-1:0] idx;
  } best_t;

endpackage

@@ design/lpr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for the route entry store.
module lpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/lpr_match.sv @@
// Shared compare unit: tests one route entry per step against the address
// and keeps the best (longest mask, lowest index) match. Uses lpr_pkg.
module lpr_match (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lpr_pkg::cmp_ctrl_t ctrl_i,
  input  lpr_pkg::entry_t    entry_i,
  input  logic [31:0]        addr_i,
  output lpr_pkg::best_t     best_o
);

  logic                    found_q, found_d;
  logic [31:0]             mask_q, mask_d;
  logic [31:0]             gw_q, gw_d;
  logic [1:0]              port_q, port_d;
  logic [lpr_pkg::IDX_W-1:0] idx_q, idx_d;
  logic                    hit;
  logic                    better;

  // Masked compare and priority test
  assign hit    = ctrl_i.in_use &&
                  ((entry_i.prefix & entry_i.mask) == (addr_i & entry_i.mask));
  assign better = !found_q || (entry_i.mask > mask_q);

  always_comb begin
    found_d = found_q;
    mask_d  = mask_q;
    gw_d    = gw_q;
    port_d  = port_q;
    idx_d   = idx_q;
    if (ctrl_i.clear) begin
      found_d = 1'b0;
    end else if (ctrl_i.step && hit && better) begin
      found_d = 1'b1;
      mask_d  = entry_i.mask;
      gw_d    = entry_i.gateway;
      port_d  = entry_i.port;
      idx_d   = ctrl_i.idx;
    end
  end

  // Hold the found flag under reset; the payload follows it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    gw_q   <= gw_d;
    port_q <= port_d;
    idx_q  <= idx_d;
  end

  assign best_o.found   = found_q;
  assign best_o.gateway = gw_q;
  assign best_o.port    = port_q;
  assign best_o.idx     = idx_q;

endmodule

@@ design/longest_prefix_route_lookup_unit.sv @@
// Longest-prefix route lookup: the top level with the scan sequencer.
// Uses lpr_pkg, lpr_ram (route store) and lpr_match (compare unit).
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item per handshake.
//   A write item (action 0) stores one route entry in the cycle it is
//   accepted and gives no result; writes with an index or port out of range
//   are dropped. A lookup item (action 1) reads the route RAM one entry per
//   cycle through the shared compare unit, then loads one result item into
//   the output register (out_valid_o / out_ready_i).
//   A lookup runs through the SCAN state, in which the single RAM read port
//   visits each entry once, then DRAIN, which waits out the registered read,
//   then LOAD, which loads the result into the output register.
//   In_ready_o is low while a lookup runs; one lookup is handled at a time.
//   A finished result waits in the output register; the next item may be
//   accepted meanwhile, and a further lookup holds in its final cycle until
//   the waiting result has been taken.
//   Reset marks every entry unused and empties the output register; entry
//   contents are undefined until written, and no clearing pass is needed.
module longest_prefix_route_lookup_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [3:0]  entry_index_i,
  input  logic        entry_valid_i,
  input  logic [31:0] route_prefix_i,
  input  logic [31:0] route_netmask_i,
  input  logic [31:0] route_gateway_i,
  input  logic [1:0]  route_port_i,
  input  logic [31:0] lookup_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        match_found_o,
  output logic [31:0] next_hop_address_o,
  output logic [1:0]  out_port_o,
  output logic [3:0]  matched_entry_o
);

  localparam int IDX_W = lpr_pkg::IDX_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_LOAD  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [31:0]      addr_q;
  logic             rd_vld_q;
  logic             rd_use_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             in_use_q [lpr_pkg::ROUTES];

  logic             in_acc;
  logic             wr_en;
  logic             lookup_acc;
  logic [IDX_W-1:0] wr_addr;
  logic             out_free;
  logic             load_res;

  lpr_pkg::entry_t    wr_entry;
  lpr_pkg::entry_t    rd_entry;
  lpr_pkg::cmp_ctrl_t cmp_ctrl;
  lpr_pkg::best_t     best;

  logic             out_valid_q;
  logic             found_q;
  logic [31:0]      hop_q;
  logic [1:0]       port_q;
  logic [3:0]       entry_q;

  // Input handshake decode
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign lookup_acc = in_acc && (action_i == lpr_pkg::ACT_LOOKUP);
  assign wr_en      = in_acc && (action_i == lpr_pkg::ACT_WRITE) &&
                      (32'(entry_index_i) < lpr_pkg::ROUTES) &&
                      (32'(route_port_i) < lpr_pkg::PORTS);
  assign wr_addr    = IDX_W'(entry_index_i);

  assign wr_entry.gateway = route_gateway_i;
  assign wr_entry.mask    = route_netmask_i;
  assign wr_entry.prefix  = route_prefix_i;
  assign wr_entry.port    = route_port_i;

  lpr_ram #(
    .WIDTH ($bits(lpr_pkg::entry_t)),
    .DEPTH (lpr_pkg::ROUTES)
  ) u_route_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_entry),
    .raddr_i (cnt_q),
    .rdata_o (rd_entry)
  );

  // In-use marks, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lpr_pkg::ROUTES; i++) begin
        in_use_q[i] <= 1'b0;
      end
    end else if (wr_en) begin
      in_use_q[wr_addr] <= entry_valid_i;
    end
  end

  // Output slot is free when empty or being emptied
  assign out_free = !out_valid_q || out_ready_i;
  assign load_res = (state_q == ST_LOAD) && out_free;

  // Scan sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (lookup_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == IDX_W'(lpr_pkg::ROUTES - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= (state_q == ST_SCAN);
    end
  end

  // Track the entry whose read data arrives next cycle
  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
    rd_use_q <= in_use_q[cnt_q];
    if (lookup_acc) begin
      addr_q <= lookup_address_i;
    end
  end

  assign cmp_ctrl.clear  = lookup_acc;
  assign cmp_ctrl.step   = rd_vld_q;
  assign cmp_ctrl.in_use = rd_use_q;
  assign cmp_ctrl.idx    = rd_idx_q;

  lpr_match u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (cmp_ctrl),
    .entry_i (rd_entry),
    .addr_i  (addr_q),
    .best_o  (best)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_res) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      found_q <= best.found;
      if (!best.found) begin
        hop_q   <= '0;
        port_q  <= '0;
        entry_q <= '0;
      end else begin
        hop_q   <= (best.gateway != 32'd0) ? best.gateway : addr_q;
        port_q  <= best.port;
        entry_q <= 4'(best.idx);
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign match_found_o      = found_q;
  assign next_hop_address_o = hop_q;
  assign out_port_o         = port_q;
  assign matched_entry_o    = entry_q;

`ifndef SYNTHESIS
  a_busy_after_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lookup_acc |=> !in_ready_o)
    else $error("input taken during a lookup scan");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_res |=> out_valid_o)
    else $error("finished lookup did not present a result");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !match_found_o) |->
      (out_port_o == 2'd0 && matched_entry_o == 4'd0 && next_hop_address_o == 32'd0))
    else $error("miss result carries non-zero fields");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !wr_en)
    else $error("route table written during a scan");
`endif

endmodule
